>>> hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned POOL_BYTES   = 4096;
  localparam int unsigned MIN_BLOCK    = 16;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned NSLOTS       = POOL_BYTES / MIN_BLOCK;
  localparam int unsigned SLOT_W       = $clog2(NSLOTS);
  localparam int unsigned MIN_ORD      = $clog2(MIN_BLOCK);
  localparam int unsigned MAX_ORD      = $clog2(POOL_BYTES);
  localparam int unsigned LO_ORD       = (MIN_ORD > 5) ? MIN_ORD : 5;
  localparam int unsigned ORD_W        = 4;
  localparam int unsigned TORD_W       = 5;

  // item modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_RESET  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_BAD_PTR  = 3'd3;
  localparam logic [2:0] ST_DBL_FREE = 3'd4;

  // config register indexes
  localparam logic CFG_POOL_BASE  = 1'b0;
  localparam logic CFG_POOL_ORDER = 1'b1;

  typedef struct packed {
    logic             start;
    logic [ORD_W-1:0] ord;
    logic             free;
  } slot_t;

  typedef struct packed {
    logic              clear;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_t             wr_data;
  } mem_req_t;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_CHECK    = 10'b0000000010,
    S_SCAN_RD  = 10'b0000000100,
    S_SCAN_EV  = 10'b0000001000,
    S_SPLIT    = 10'b0000010000,
    S_FREE_RD  = 10'b0000100000,
    S_FREE_EV  = 10'b0001000000,
    S_MERGE_RD = 10'b0010000000,
    S_MERGE_EV = 10'b0100000000,
    S_RESP     = 10'b1000000000
  } state_e;

  // number of significant bits of v (0 for v == 0)
  function automatic logic [TORD_W-1:0] bit_len(input logic [16:0] v);
    logic [TORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < 17; i++) begin
      if (v[i]) begin
        r = TORD_W'(i + 1);
      end
    end
    return r;
  endfunction

endpackage

>>> hdl/bba_slot_store.sv
// ----------------------------------------------------------------------------
// bba_slot_store
// Slot header memory with per-slot valid bits; invalid slots read as reset.
// ----------------------------------------------------------------------------
module bba_slot_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bba_pkg::mem_req_t              req_i,
  input  logic [bba_pkg::ORD_W-1:0]      eff_ord_i,
  output bba_pkg::slot_t                 rd_data_o
);

  bba_pkg::slot_t                mem [bba_pkg::NSLOTS];
  logic [bba_pkg::NSLOTS-1:0]    vld_q;
  bba_pkg::slot_t                rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clear) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // registered read; slot zero defaults to the whole pool, free
  always_ff @(posedge clk_i) begin
    if (vld_q[req_i.rd_addr]) begin
      rd_q <= mem[req_i.rd_addr];
    end else if (req_i.rd_addr == '0) begin
      rd_q <= '{start: 1'b1, ord: eff_ord_i, free: 1'b1};
    end else begin
      rd_q <= '0;
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> hdl/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Power-of-two buddy allocator: allocate, free with buddy merge, pool reset.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------
//  in      | in        | in_valid_i / in_stall_o    | mode_i, req_bytes_i, free_addr_i
//  out     | out       | out_valid_o / out_stall_i  | ok_o, payload_addr_o, status_o
//  cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
//  One item at a time through a sequencer around a slot memory with one read and
//  one write port. Allocate scans every block (up to 256) with a read and an
//  evaluate state, then splits; free reads, checks, then merges level by level.
//  Reset state is one free block over the whole pool; no clearing pass, the
//  per-slot valid bits clear at once. Config writes are taken only while idle.
//  Output is registered, so a stalled result holds while the next item is
//  already accepted.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] req_bytes_i,
  input  logic [31:0] free_addr_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        ok_o,
  output logic [31:0] payload_addr_o,
  output logic [2:0]  status_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned SW = bba_pkg::SLOT_W;
  localparam int unsigned OW = bba_pkg::ORD_W;
  localparam int unsigned TORD_W_L = bba_pkg::TORD_W;

  bba_pkg::state_e   state_q, state_d;

  logic [31:0]       base_q;
  logic [OW-1:0]     pool_ord_q;
  logic [OW-1:0]     eff_ord;
  logic [SW:0]       nslots;

  // latched item
  logic [1:0]        mode_q;
  logic [15:0]       bytes_q;
  logic [31:0]       faddr_q;

  // sequencer registers
  logic [SW:0]       scan_q, scan_d;
  logic [SW-1:0]     best_q, best_d;
  logic [OW-1:0]     best_ord_q, best_ord_d;
  logic              found_q, found_d;
  logic [OW-1:0]     tord_q, tord_d;
  logic [SW-1:0]     cur_q, cur_d;
  logic [OW-1:0]     cur_ord_q, cur_ord_d;

  // pending result
  logic              res_ok_q, res_ok_d;
  logic [31:0]       res_addr_q, res_addr_d;
  logic [2:0]        res_st_q, res_st_d;

  // output register
  logic              out_vld_q;
  logic              ok_q;
  logic [31:0]       addr_q;
  logic [2:0]        st_q;

  bba_pkg::mem_req_t mreq;
  bba_pkg::slot_t    rword;

  logic              in_acc, cfg_acc, load_out;

  // CHECK-stage arithmetic
  logic [16:0]       need;
  logic [TORD_W_L-1:0] tord_c;
  logic [32:0]       lo_lim, hi_lim, off33;
  logic [SW-1:0]     fslot;

  // scan / merge arithmetic
  logic              take;
  logic [SW:0]       scan_nxt;
  logic [OW-1:0]     split_ord;
  logic [SW-1:0]     bud;

  always_comb begin
    eff_ord = pool_ord_q;
    if (pool_ord_q < OW'(bba_pkg::LO_ORD)) eff_ord = OW'(bba_pkg::LO_ORD);
    if (pool_ord_q > OW'(bba_pkg::MAX_ORD)) eff_ord = OW'(bba_pkg::MAX_ORD);
  end
  assign nslots = (SW+1)'(1) << (eff_ord - OW'(bba_pkg::MIN_ORD));

  assign in_stall_o  = (state_q != bba_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == bba_pkg::S_IDLE);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= '0;
      pool_ord_q <= OW'(12);
    end else if (cfg_acc) begin
      if (cfg_index_i == bba_pkg::CFG_POOL_BASE) begin
        base_q <= cfg_data_i;
      end else begin
        pool_ord_q <= cfg_data_i[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= mode_i;
      bytes_q <= req_bytes_i;
      faddr_q <= free_addr_i;
    end
  end

  // size rounding: smallest order >= MIN_ORD holding bytes + header
  assign need   = {1'b0, bytes_q} + 17'(bba_pkg::HEADER_BYTES);
  always_comb begin
    tord_c = bba_pkg::bit_len(need - 17'd1);
    if (tord_c < TORD_W_L'(bba_pkg::MIN_ORD)) tord_c = TORD_W_L'(bba_pkg::MIN_ORD);
  end

  // pointer range check
  assign lo_lim = {1'b0, base_q} + 33'(bba_pkg::HEADER_BYTES);
  assign hi_lim = {1'b0, base_q} + (33'd1 << eff_ord);
  assign off33  = {1'b0, faddr_q} - lo_lim;
  assign fslot  = off33[bba_pkg::MAX_ORD-1:bba_pkg::MIN_ORD];

  // scan step
  assign take = rword.free && (rword.ord >= tord_q)
             && (!found_q || rword.ord < best_ord_q);
  assign scan_nxt  = scan_q + ((SW+1)'(1) << (rword.ord - OW'(bba_pkg::MIN_ORD)));
  assign split_ord = best_ord_q - OW'(1);
  assign bud       = cur_q ^ (SW'(1) << (cur_ord_q - OW'(bba_pkg::MIN_ORD)));

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    best_d     = best_q;
    best_ord_d = best_ord_q;
    found_d    = found_q;
    tord_d     = tord_q;
    cur_d      = cur_q;
    cur_ord_d  = cur_ord_q;
    res_ok_d   = res_ok_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    load_out   = 1'b0;

    mreq         = '0;
    mreq.clear   = cfg_acc && (cfg_index_i == bba_pkg::CFG_POOL_ORDER);
    mreq.rd_addr = scan_q[SW-1:0];

    unique case (state_q)
      bba_pkg::S_IDLE: begin
        if (in_acc) state_d = bba_pkg::S_CHECK;
      end

      bba_pkg::S_CHECK: begin
        res_ok_d   = 1'b0;
        res_addr_d = '0;
        res_st_d   = bba_pkg::ST_BAD_PTR;
        state_d    = bba_pkg::S_RESP;
        case (mode_q)
          bba_pkg::MODE_ALLOC: begin
            if (bytes_q == '0 || tord_c > TORD_W_L'(eff_ord)) begin
              res_st_d = bba_pkg::ST_BAD_SIZE;
            end else begin
              tord_d  = tord_c[OW-1:0];
              scan_d  = '0;
              found_d = 1'b0;
              state_d = bba_pkg::S_SCAN_RD;
            end
          end
          bba_pkg::MODE_FREE: begin
            if ({1'b0, faddr_q} < lo_lim || {1'b0, faddr_q} >= hi_lim
                || off33[bba_pkg::MIN_ORD-1:0] != '0
                || {1'b0, fslot} >= nslots) begin
              res_st_d = bba_pkg::ST_BAD_PTR;
            end else begin
              cur_d   = fslot;
              state_d = bba_pkg::S_FREE_RD;
            end
          end
          bba_pkg::MODE_RESET: begin
            mreq.clear = 1'b1;
            res_ok_d   = 1'b1;
            res_st_d   = bba_pkg::ST_OK;
          end
          default: begin
            res_st_d = bba_pkg::ST_BAD_PTR;
          end
        endcase
      end

      bba_pkg::S_SCAN_RD: begin
        mreq.rd_addr = scan_q[SW-1:0];
        state_d      = bba_pkg::S_SCAN_EV;
      end

      bba_pkg::S_SCAN_EV: begin
        if (!rword.start || rword.ord < OW'(bba_pkg::MIN_ORD) || rword.ord > eff_ord) begin
          res_ok_d   = 1'b0;
          res_addr_d = '0;
          res_st_d   = bba_pkg::ST_NO_FIT;
          state_d    = bba_pkg::S_RESP;
        end else begin
          if (take) begin
            best_d     = scan_q[SW-1:0];
            best_ord_d = rword.ord;
            found_d    = 1'b1;
          end
          scan_d = scan_nxt;
          if (scan_nxt >= nslots) begin
            if (take || found_q) begin
              state_d = bba_pkg::S_SPLIT;
            end else begin
              res_ok_d   = 1'b0;
              res_addr_d = '0;
              res_st_d   = bba_pkg::ST_NO_FIT;
              state_d    = bba_pkg::S_RESP;
            end
          end else begin
            state_d = bba_pkg::S_SCAN_RD;
          end
        end
      end

      // one halving per cycle; the upper half becomes a free buddy
      bba_pkg::S_SPLIT: begin
        mreq.wr_en = 1'b1;
        if (best_ord_q > tord_q) begin
          mreq.wr_addr = best_q + (SW'(1) << (split_ord - OW'(bba_pkg::MIN_ORD)));
          mreq.wr_data = '{start: 1'b1, ord: split_ord, free: 1'b1};
          best_ord_d   = split_ord;
        end else begin
          mreq.wr_addr = best_q;
          mreq.wr_data = '{start: 1'b1, ord: tord_q, free: 1'b0};
          res_ok_d     = 1'b1;
          res_addr_d   = base_q + {{(32-SW-bba_pkg::MIN_ORD){1'b0}}, best_q,
                                   {bba_pkg::MIN_ORD{1'b0}}}
                              + 32'(bba_pkg::HEADER_BYTES);
          res_st_d     = bba_pkg::ST_OK;
          state_d      = bba_pkg::S_RESP;
        end
      end

      bba_pkg::S_FREE_RD: begin
        mreq.rd_addr = cur_q;
        state_d      = bba_pkg::S_FREE_EV;
      end

      bba_pkg::S_FREE_EV: begin
        res_ok_d   = 1'b0;
        res_addr_d = '0;
        if (!rword.start) begin
          res_st_d = bba_pkg::ST_BAD_PTR;
          state_d  = bba_pkg::S_RESP;
        end else if (rword.free) begin
          res_st_d = bba_pkg::ST_DBL_FREE;
          state_d  = bba_pkg::S_RESP;
        end else begin
          cur_ord_d = rword.ord;
          state_d   = bba_pkg::S_MERGE_RD;
        end
      end

      // read the buddy, or close out when the top order is reached
      bba_pkg::S_MERGE_RD: begin
        mreq.rd_addr = bud;
        if (cur_ord_q < eff_ord && cur_ord_q >= OW'(bba_pkg::MIN_ORD)) begin
          state_d = bba_pkg::S_MERGE_EV;
        end else begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = cur_q;
          mreq.wr_data = '{start: 1'b1, ord: cur_ord_q, free: 1'b1};
          res_ok_d     = 1'b1;
          res_addr_d   = '0;
          res_st_d     = bba_pkg::ST_OK;
          state_d      = bba_pkg::S_RESP;
        end
      end

      bba_pkg::S_MERGE_EV: begin
        mreq.wr_en = 1'b1;
        if ({1'b0, bud} >= nslots || !rword.start || !rword.free
            || rword.ord != cur_ord_q) begin
          mreq.wr_addr = cur_q;
          mreq.wr_data = '{start: 1'b1, ord: cur_ord_q, free: 1'b1};
          res_ok_d     = 1'b1;
          res_addr_d   = '0;
          res_st_d     = bba_pkg::ST_OK;
          state_d      = bba_pkg::S_RESP;
        end else begin
          // retire the upper header; the lower one is written at the end
          mreq.wr_addr = (bud < cur_q) ? cur_q : bud;
          mreq.wr_data = '0;
          cur_d        = (bud < cur_q) ? bud : cur_q;
          cur_ord_d    = cur_ord_q + OW'(1);
          state_d      = bba_pkg::S_MERGE_RD;
        end
      end

      bba_pkg::S_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = bba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bba_pkg::S_IDLE;
      end
    endcase
  end

  bba_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mreq),
    .eff_ord_i (eff_ord),
    .rd_data_o (rword)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bba_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    best_q     <= best_d;
    best_ord_q <= best_ord_d;
    found_q    <= found_d;
    tord_q     <= tord_d;
    cur_q      <= cur_d;
    cur_ord_q  <= cur_ord_d;
    res_ok_q   <= res_ok_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (load_out) begin
      ok_q   <= res_ok_q;
      addr_q <= res_addr_q;
      st_q   <= res_st_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign ok_o           = ok_q;
  assign payload_addr_o = addr_q;
  assign status_o       = st_q;

endmodule

>>> tb/buddy_block_allocator_core_tb.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core_tb
// Self-checking bench: allocate, free, pool reset and unknown-mode items run against a
// slot-level buddy predictor; results checked field by field in order.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core_tb;

  typedef struct packed {
    logic        ok;
    logic [31:0] addr;
    logic [2:0]  status;
  } alloc_rsp_t;

  // Predictor of the pool plus the queue of results it has promised.
  class alloc_scoreboard;
    logic [31:0] base;
    logic [3:0]  order_reg;
    bit          is_start [bba_pkg::NSLOTS];
    int unsigned ord [bba_pkg::NSLOTS];
    bit          is_free [bba_pkg::NSLOTS];
    alloc_rsp_t  pending [$];
    int unsigned errors;
    int unsigned checked;

    function int unsigned live_order();
      int unsigned o;
      o = order_reg;
      if (o < bba_pkg::LO_ORD) o = bba_pkg::LO_ORD;
      if (o > bba_pkg::MAX_ORD) o = bba_pkg::MAX_ORD;
      return o;
    endfunction

    function int unsigned live_slots();
      return 1 << (live_order() - bba_pkg::MIN_ORD);
    endfunction

    function void rebuild();
      for (int k = 0; k < bba_pkg::NSLOTS; k++) begin
        is_start[k] = 0;
        ord[k] = 0;
        is_free[k] = 0;
      end
      is_start[0] = 1;
      ord[0] = live_order();
      is_free[0] = 1;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == bba_pkg::CFG_POOL_BASE) begin
        base = data;
      end else begin
        order_reg = data[3:0];
        rebuild();
      end
    endfunction

    function alloc_rsp_t do_alloc(logic [15:0] req);
      alloc_rsp_t r;
      int unsigned po, n, target, tord, s, best, o, bud;
      bit found;
      r = '{ok: 1'b0, addr: 32'd0, status: bba_pkg::ST_BAD_SIZE};
      po = live_order();
      n = live_slots();
      if (req == 0) return r;
      target = bba_pkg::MIN_BLOCK;
      tord = bba_pkg::MIN_ORD;
      while (target < req + bba_pkg::HEADER_BYTES) begin
        target = target << 1;
        tord++;
      end
      if (tord > po) return r;
      r.status = bba_pkg::ST_NO_FIT;
      found = 0;
      best = 0;
      s = 0;
      while (s < n) begin
        o = ord[s];
        if (!is_start[s] || o < bba_pkg::MIN_ORD || o > po) return r;
        if (is_free[s] && o >= tord && (!found || o < ord[best])) begin
          best = s;
          found = 1;
        end
        s += 1 << (o - bba_pkg::MIN_ORD);
      end
      if (!found) return r;
      while (ord[best] > tord) begin
        o = ord[best] - 1;
        bud = best + (1 << (o - bba_pkg::MIN_ORD));
        ord[best] = o;
        if (bud < bba_pkg::NSLOTS) begin
          is_start[bud] = 1;
          ord[bud] = o;
          is_free[bud] = 1;
        end
      end
      is_free[best] = 0;
      r.ok = 1'b1;
      r.status = bba_pkg::ST_OK;
      r.addr = base + best * bba_pkg::MIN_BLOCK + bba_pkg::HEADER_BYTES;
      return r;
    endfunction

    function alloc_rsp_t do_free(logic [31:0] a);
      alloc_rsp_t r;
      longint unsigned la, lb, off;
      int unsigned po, n, s, o, bud, lo, hi;
      r = '{ok: 1'b0, addr: 32'd0, status: bba_pkg::ST_BAD_PTR};
      po = live_order();
      n = live_slots();
      la = a;
      lb = base;
      if (la < lb + bba_pkg::HEADER_BYTES || la >= lb + (64'd1 << po)) return r;
      off = la - lb - bba_pkg::HEADER_BYTES;
      if (off % bba_pkg::MIN_BLOCK != 0) return r;
      s = 32'(off / bba_pkg::MIN_BLOCK);
      if (s >= n || !is_start[s]) return r;
      if (is_free[s]) begin
        r.status = bba_pkg::ST_DBL_FREE;
        return r;
      end
      is_free[s] = 1;
      while (ord[s] < po && ord[s] >= bba_pkg::MIN_ORD) begin
        o = ord[s];
        bud = s ^ (1 << (o - bba_pkg::MIN_ORD));
        if (bud >= n || !is_start[bud] || !is_free[bud] || ord[bud] != o) break;
        lo = bud < s ? bud : s;
        hi = bud < s ? s : bud;
        is_start[hi] = 0;
        is_free[hi] = 0;
        ord[hi] = 0;
        ord[lo] = o + 1;
        is_free[lo] = 1;
        s = lo;
      end
      r.ok = 1'b1;
      r.status = bba_pkg::ST_OK;
      return r;
    endfunction

    function void note_item(logic [1:0] m, logic [15:0] req, logic [31:0] a);
      alloc_rsp_t r;
      if (m == bba_pkg::MODE_ALLOC) begin
        r = do_alloc(req);
      end else if (m == bba_pkg::MODE_FREE) begin
        r = do_free(a);
      end else if (m == bba_pkg::MODE_RESET) begin
        rebuild();
        r = '{ok: 1'b1, addr: 32'd0, status: bba_pkg::ST_OK};
      end else begin
        r = '{ok: 1'b0, addr: 32'd0, status: bba_pkg::ST_BAD_PTR};
      end
      pending.push_back(r);
    endfunction

    function void check_result(alloc_rsp_t got);
      alloc_rsp_t e;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result ok=%0b addr=%h status=%0d", got.ok, got.addr, got.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ok !== e.ok) begin
        $error("ok: expected %0b actual %0b", e.ok, got.ok);
        errors++;
      end
      if (got.addr !== e.addr) begin
        $error("payload_addr: expected %h actual %h", e.addr, got.addr);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i = bba_pkg::MODE_ALLOC;
  logic [15:0] req_bytes_i = '0;
  logic [31:0] free_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        ok_o;
  logic [31:0] payload_addr_o;
  logic [2:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = bba_pkg::CFG_POOL_BASE;
  logic [31:0] cfg_data_i = '0;

  buddy_block_allocator_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  alloc_scoreboard sb = new();

  // Idle percentages per side; hold_off forces a long receiver stall.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off = 0;
  int unsigned items_sent = 0;
  logic [31:0] live_ptrs [$];   // payload addresses handed out, for frees

  // Receiver: random stall, with an optional counted hold-off.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result('{ok: ok_o, addr: payload_addr_o, status: status_o});
      if (ok_o && status_o == bba_pkg::ST_OK && payload_addr_o != 0) begin
        live_ptrs.push_back(payload_addr_o);
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // One item; the random gap comes first so valid stays high across items.
  task automatic send_item(logic [1:0] m, logic [15:0] req, logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    req_bytes_i <= req;
    free_addr_i <= a;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(m, req, a);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    // idle gap after the last result has been checked
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
    live_ptrs.delete();
  endtask

  // Mostly alloc/free of live blocks, with some noise and corner items.
  task automatic random_item();
    int unsigned pick;
    int unsigned idx;
    logic [31:0] a;
    pick = $urandom_range(99);
    if (pick < 45) begin
      if ($urandom_range(9) == 0) send_item(bba_pkg::MODE_ALLOC, 16'($urandom), '0);
      else send_item(bba_pkg::MODE_ALLOC, 16'($urandom_range(1, 300)), 32'($urandom));
    end else if (pick < 85 && live_ptrs.size() > 0) begin
      idx = $urandom_range(live_ptrs.size() - 1);
      a = live_ptrs[idx];
      if ($urandom_range(3) != 0) live_ptrs.delete(idx);
      send_item(bba_pkg::MODE_FREE, 16'($urandom), a);
    end else if (pick < 92) begin
      a = $urandom_range(3) == 0 ? 32'($urandom)
                                 : sb.base + 32'($urandom_range(0, 4200));
      send_item(bba_pkg::MODE_FREE, 16'($urandom), a);
    end else if (pick < 96) begin
      send_item(bba_pkg::MODE_RESET, 16'($urandom), 32'($urandom));
      live_ptrs.delete();
    end else begin
      send_item(bba_pkg::MODE_UNUSED, 16'($urandom), 32'($urandom));
    end
  endtask

  initial begin
    #200000000;
    $display("buddy_block_allocator_core verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sb.base = 32'd0;
    sb.order_reg = 4'd12;
    sb.rebuild();
    sb.errors = 0;
    sb.checked = 0;

    // Directed: field extremes, every mode, each corner case.
    send_item(bba_pkg::MODE_ALLOC, 16'd0, 32'hFFFF_FFFF);   // zero size
    send_item(bba_pkg::MODE_ALLOC, 16'hFFFF, 32'd0);        // too large
    send_item(bba_pkg::MODE_ALLOC, 16'd4080, '0);           // whole pool
    send_item(bba_pkg::MODE_ALLOC, 16'd1, '0);              // no fit
    send_item(bba_pkg::MODE_FREE, '0, 32'd16);              // merge back to pool
    send_item(bba_pkg::MODE_FREE, '0, 32'd16);              // double free
    send_item(bba_pkg::MODE_FREE, '0, 32'd0);               // below base+header
    send_item(bba_pkg::MODE_FREE, '0, 32'd4096);            // past end
    send_item(bba_pkg::MODE_FREE, '0, 32'd17);              // misaligned
    send_item(bba_pkg::MODE_FREE, '0, 32'hFFFF_FFFF);
    send_item(bba_pkg::MODE_ALLOC, 16'd1, '0);
    send_item(bba_pkg::MODE_ALLOC, 16'd17, '0);
    send_item(bba_pkg::MODE_FREE, '0, 32'd48);              // free of a block that is already free
    send_item(bba_pkg::MODE_ALLOC, 16'd100, '0);
    send_item(bba_pkg::MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF); // unknown mode
    send_item(bba_pkg::MODE_RESET, '0, '0);
    drain();

    // Address wrap with the extreme base and smallest pool.
    write_reg(bba_pkg::CFG_POOL_BASE, 32'hFFFF_FFF0);
    write_reg(bba_pkg::CFG_POOL_ORDER, 32'd0);               // saturates up
    send_item(bba_pkg::MODE_ALLOC, 16'd1, '0);
    send_item(bba_pkg::MODE_ALLOC, 16'd1, '0);
    send_item(bba_pkg::MODE_ALLOC, 16'd1, '0);
    send_item(bba_pkg::MODE_FREE, '0, 32'h0000_0000);
    send_item(bba_pkg::MODE_FREE, '0, 32'h0000_0010);
    drain();

    // Random phases over several pool settings and idling mixes.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
        4: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        default: begin send_idle_pct = 7; recv_stall_pct = 59; end
      endcase
      write_reg(bba_pkg::CFG_POOL_BASE,
                ph == 4 ? 32'd0 : 32'($urandom) & 32'hFFFF_FFF0);
      write_reg(bba_pkg::CFG_POOL_ORDER,
                ph == 0 ? 32'd15 : ph == 4 ? 32'd5 : 32'($urandom_range(5, 12)));
      if (ph == 2) hold_off = 3000;   // block backs up while items keep coming
      for (int i = 0; i < 80; i++) random_item();
      if (ph == 3) begin
        // sender waits for everything outstanding, then continues
        in_valid_i <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
        for (int i = 0; i < 10; i++) random_item();
      end
      drain();
    end

    $display("covered %0d items, %0d results, six pool settings incl. min/max order",
             items_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("buddy_block_allocator_core verification clean");
    end else begin
      $display("buddy_block_allocator_core verification failed");
    end
    $finish;
  end

endmodule
